// ===== rtl/toeq_pkg.sv =====
`default_nettype none
package toeq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int TAG_W   = 16;
  localparam int FILL_W  = 5;
  localparam int STAT_W  = 2;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  localparam logic [STAT_W-1:0] ST_PUSH_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_PULL_DONE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_QUEUE_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_QUEUE_EMPT = 2'd3;

  typedef struct packed {
    logic [SEC_W-1:0]  seconds;
    logic [USEC_W-1:0] micros;
    logic              kind;
    logic [TAG_W-1:0]  tag;
  } event_t;

  // Shift command shared by every cell of the row
  typedef struct packed {
    logic update;
    logic push;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/toeq_cell.sv =====
`default_nettype none
module toeq_cell (
  input  wire                 clk,
  input  toeq_pkg::cell_ctrl_t ctrl,
  input  toeq_pkg::event_t    new_evt,
  input  toeq_pkg::event_t    left_evt,
  input  wire                 left_flag,
  input  toeq_pkg::event_t    right_evt,
  input  wire                 occupied,
  output toeq_pkg::event_t    evt,
  output logic                flag
);

  toeq_pkg::event_t slot_r;
  toeq_pkg::event_t slot_nxt;
  logic             not_earlier;

  // stored deadline at or after the new one
  always_comb begin
    if (slot_r.seconds != new_evt.seconds) begin
      not_earlier = slot_r.seconds > new_evt.seconds;
    end else begin
      not_earlier = slot_r.micros >= new_evt.micros;
    end
  end

  assign flag = !occupied || not_earlier;

  always_comb begin
    if (ctrl.push) begin
      priority if (left_flag) begin
        slot_nxt = left_evt;
      end else if (flag) begin
        slot_nxt = new_evt;
      end else begin
        slot_nxt = slot_r;
      end
    end else begin
      slot_nxt = right_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      slot_r <= slot_nxt;
    end
  end

  assign evt = slot_r;

endmodule
`default_nettype wire

// ===== rtl/toeq_delta.sv =====
`default_nettype none
module toeq_delta (
  input  toeq_pkg::event_t                   head_evt,
  input  toeq_pkg::event_t                   next_evt,
  output logic [toeq_pkg::SEC_W-1:0]         delta_seconds,
  output logic [toeq_pkg::USEC_W-1:0]        delta_micros
);

  logic [toeq_pkg::USEC_W:0] usec_diff;
  logic                      borrow;

  assign usec_diff = {1'b0, next_evt.micros} - {1'b0, head_evt.micros};
  assign borrow    = usec_diff[toeq_pkg::USEC_W];

  assign delta_micros = borrow ?
      usec_diff[toeq_pkg::USEC_W-1:0] + toeq_pkg::USEC_PER_SEC :
      usec_diff[toeq_pkg::USEC_W-1:0];

  assign delta_seconds = next_evt.seconds - head_evt.seconds
                         - {{(toeq_pkg::SEC_W-1){1'b0}}, borrow};

endmodule
`default_nettype wire

// ===== rtl/time_ordered_event_queue_unit.sv =====
`default_nettype none
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_mode, in_event_seconds/micros/kind/tag
// out     | output    | out_valid, out_ready, out_status, out_seconds/micros/kind/tag,
//         |           | out_next_valid, out_delta_seconds/micros, out_fill_count
//
// The cell row shifts once per accepted push into a non-full queue or pull from a
// non-empty one; the result is registered on acceptance and shown in the next cycle.
// An item is taken while the result register is empty or being drained.
// Reset (rst_n low, synchronous) empties the queue and the result register; slot
// contents are not cleared.
// A stalled out channel holds the result and blocks new items.
module time_ordered_event_queue_unit #(
  parameter int QUEUE_DEPTH = toeq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_mode,
  input  wire  [toeq_pkg::SEC_W-1:0]       in_event_seconds,
  input  wire  [toeq_pkg::USEC_W-1:0]      in_event_micros,
  input  wire                              in_event_kind,
  input  wire  [toeq_pkg::TAG_W-1:0]       in_event_tag,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [toeq_pkg::STAT_W-1:0]      out_status,
  output logic [toeq_pkg::SEC_W-1:0]       out_seconds,
  output logic [toeq_pkg::USEC_W-1:0]      out_micros,
  output logic                             out_kind,
  output logic [toeq_pkg::TAG_W-1:0]       out_tag,
  output logic                             out_next_valid,
  output logic [toeq_pkg::SEC_W-1:0]       out_delta_seconds,
  output logic [toeq_pkg::USEC_W-1:0]      out_delta_micros,
  output logic [toeq_pkg::FILL_W-1:0]      out_fill_count
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  toeq_pkg::event_t     new_evt;
  toeq_pkg::event_t     evt_a  [QUEUE_DEPTH];
  logic                 flag_a [QUEUE_DEPTH];
  toeq_pkg::cell_ctrl_t ctrl;

  logic in_fire;
  logic is_push;
  logic full;
  logic empty;
  logic has_next;

  logic [toeq_pkg::SEC_W-1:0]  delta_seconds;
  logic [toeq_pkg::USEC_W-1:0] delta_micros;

  logic                          out_valid_r;
  logic [toeq_pkg::STAT_W-1:0]   status_r,  status_nxt;
  toeq_pkg::event_t              pulled_r,  pulled_nxt;
  logic                          nvalid_r,  nvalid_nxt;
  logic [toeq_pkg::SEC_W-1:0]    dsec_r,    dsec_nxt;
  logic [toeq_pkg::USEC_W-1:0]   dusec_r,   dusec_nxt;
  logic [toeq_pkg::FILL_W-1:0]   fill_r,    fill_nxt;
  logic [CW+toeq_pkg::FILL_W-1:0] fill_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_push  = (in_mode == toeq_pkg::MODE_PUSH);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign has_next = (count_r > CW'(1));

  assign new_evt.seconds = in_event_seconds;
  assign new_evt.micros  = in_event_micros;
  assign new_evt.kind    = in_event_kind;
  assign new_evt.tag     = in_event_tag;

  assign ctrl.push   = is_push;
  assign ctrl.update = in_fire && (is_push ? !full : !empty);

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      toeq_pkg::event_t left_evt;
      toeq_pkg::event_t right_evt;
      logic             left_flag;

      if (gi == 0) begin : g_first
        assign left_evt  = new_evt;
        assign left_flag = 1'b0;
      end else begin : g_mid
        assign left_evt  = evt_a[gi-1];
        assign left_flag = flag_a[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_evt = evt_a[gi];
      end else begin : g_body
        assign right_evt = evt_a[gi+1];
      end

      toeq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_evt   (new_evt),
        .left_evt  (left_evt),
        .left_flag (left_flag),
        .right_evt (right_evt),
        .occupied  (CW'(gi) < count_r),
        .evt       (evt_a[gi]),
        .flag      (flag_a[gi])
      );
    end
  endgenerate

  toeq_delta u_delta (
    .head_evt      (evt_a[0]),
    .next_evt      (evt_a[1]),
    .delta_seconds (delta_seconds),
    .delta_micros  (delta_micros)
  );

  always_comb begin
    count_nxt  = count_r;
    status_nxt = toeq_pkg::ST_PUSH_DONE;
    pulled_nxt = '0;
    nvalid_nxt = 1'b0;
    dsec_nxt   = '0;
    dusec_nxt  = '0;
    if (is_push) begin
      if (full) begin
        status_nxt = toeq_pkg::ST_QUEUE_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = toeq_pkg::ST_QUEUE_EMPT;
      end else begin
        status_nxt = toeq_pkg::ST_PULL_DONE;
        count_nxt  = count_r - CW'(1);
        pulled_nxt = evt_a[0];
        if (has_next) begin
          nvalid_nxt = 1'b1;
          dsec_nxt   = delta_seconds;
          dusec_nxt  = delta_micros;
        end
      end
    end
    fill_ext = {{toeq_pkg::FILL_W{1'b0}}, count_nxt};
    fill_nxt = fill_ext[toeq_pkg::FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, held while the out side stalls
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      pulled_r <= pulled_nxt;
      nvalid_r <= nvalid_nxt;
      dsec_r   <= dsec_nxt;
      dusec_r  <= dusec_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_seconds       = pulled_r.seconds;
  assign out_micros        = pulled_r.micros;
  assign out_kind          = pulled_r.kind;
  assign out_tag           = pulled_r.tag;
  assign out_next_valid    = nvalid_r;
  assign out_delta_seconds = dsec_r;
  assign out_delta_micros  = dusec_r;
  assign out_fill_count    = fill_r;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int DEPTH       = toeq_pkg::DEFAULT_QUEUE_DEPTH;
  localparam int SEC_W       = toeq_pkg::SEC_W;
  localparam int USEC_W      = toeq_pkg::USEC_W;
  localparam int TAG_W       = toeq_pkg::TAG_W;
  localparam int FILL_W      = toeq_pkg::FILL_W;
  localparam int STAT_W      = toeq_pkg::STAT_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 616;
  localparam int BURST_ITEMS = 40;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SEC_W-1:0]  seconds;
    logic [USEC_W-1:0] micros;
    logic              kind;
    logic [TAG_W-1:0]  tag;
    logic              next_valid;
    logic [SEC_W-1:0]  delta_seconds;
    logic [USEC_W-1:0] delta_micros;
    logic [FILL_W-1:0] fill;
  } timer_result_t;

  typedef struct {
    logic              mode;
    toeq_pkg::event_t  ev;
    bit                typed;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill;
  } plan_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = toeq_pkg::MODE_PUSH;
  logic [SEC_W-1:0] in_event_seconds = '0;
  logic [USEC_W-1:0] in_event_micros = '0;
  logic in_event_kind = 1'b0;
  logic [TAG_W-1:0] in_event_tag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [SEC_W-1:0] out_seconds;
  logic [USEC_W-1:0] out_micros;
  logic out_kind;
  logic [TAG_W-1:0] out_tag;
  logic out_next_valid;
  logic [SEC_W-1:0] out_delta_seconds;
  logic [USEC_W-1:0] out_delta_micros;
  logic [FILL_W-1:0] out_fill_count;

  toeq_pkg::event_t timer_slots [DEPTH];
  int timer_count = 0;
  timer_result_t awaited_results[$];
  plan_row_t directed_plan[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  time_ordered_event_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_event_seconds(in_event_seconds),
    .in_event_micros(in_event_micros),
    .in_event_kind(in_event_kind),
    .in_event_tag(in_event_tag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_seconds(out_seconds),
    .out_micros(out_micros),
    .out_kind(out_kind),
    .out_tag(out_tag),
    .out_next_valid(out_next_valid),
    .out_delta_seconds(out_delta_seconds),
    .out_delta_micros(out_delta_micros),
    .out_fill_count(out_fill_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("time_ordered_event_queue_unit verification failed");
      $finish;
    end
  end

  // Sorted insert and head removal with the next-timeout delta.
  function automatic timer_result_t timer_queue_step(input logic mode,
                                                     input toeq_pkg::event_t ev);
    timer_result_t r;
    toeq_pkg::event_t pulled;
    int pos;
    r = '0;
    if (mode == toeq_pkg::MODE_PUSH) begin
      if (timer_count >= DEPTH) begin
        r.status = toeq_pkg::ST_QUEUE_FULL;
        r.fill = FILL_W'(timer_count);
      end else begin
        pos = 0;
        // a new event goes ahead of any stored one with an equal deadline
        while (pos < timer_count &&
               {timer_slots[pos].seconds, timer_slots[pos].micros} <
               {ev.seconds, ev.micros})
          pos++;
        for (int i = timer_count; i > pos; i--)
          timer_slots[i] = timer_slots[i-1];
        timer_slots[pos] = ev;
        timer_count++;
        r.status = toeq_pkg::ST_PUSH_DONE;
        r.fill = FILL_W'(timer_count);
      end
    end else if (timer_count == 0) begin
      r.status = toeq_pkg::ST_QUEUE_EMPT;
    end else begin
      pulled = timer_slots[0];
      r.status = toeq_pkg::ST_PULL_DONE;
      r.seconds = pulled.seconds;
      r.micros = pulled.micros;
      r.kind = pulled.kind;
      r.tag = pulled.tag;
      for (int i = 1; i < timer_count; i++)
        timer_slots[i-1] = timer_slots[i];
      timer_count--;
      if (timer_count > 0) begin
        r.next_valid = 1'b1;
        r.delta_seconds = timer_slots[0].seconds - pulled.seconds;
        if (timer_slots[0].micros < pulled.micros) begin
          r.delta_micros = timer_slots[0].micros + toeq_pkg::USEC_PER_SEC - pulled.micros;
          r.delta_seconds = r.delta_seconds - SEC_W'(1);
        end else begin
          r.delta_micros = timer_slots[0].micros - pulled.micros;
        end
      end
      r.fill = FILL_W'(timer_count);
    end
    return r;
  endfunction

  function automatic toeq_pkg::event_t make_event(input logic [SEC_W-1:0] s,
                                                  input logic [USEC_W-1:0] us,
                                                  input logic k, input logic [TAG_W-1:0] t);
    toeq_pkg::event_t ev;
    ev.seconds = s;
    ev.micros = us;
    ev.kind = k;
    ev.tag = t;
    return ev;
  endfunction

  task automatic plan_row(input logic mode, input toeq_pkg::event_t ev, input bit typed,
                          input logic [STAT_W-1:0] status, input logic [FILL_W-1:0] fill);
    plan_row_t row;
    row.mode = mode;
    row.ev = ev;
    row.typed = typed;
    row.status = status;
    row.fill = fill;
    directed_plan.push_back(row);
  endtask

  // Deadlines cluster near an epoch so that ties and borrows come up often.
  function automatic toeq_pkg::event_t random_event(input logic [SEC_W-1:0] epoch);
    toeq_pkg::event_t ev;
    ev.seconds = ($urandom_range(29) == 0) ? $urandom : epoch + $urandom_range(3);
    case ($urandom_range(5))
      0: ev.micros = '0;
      1: ev.micros = USEC_W'(999999);
      2: ev.micros = USEC_W'($urandom_range(999999, 999990));
      3: ev.micros = USEC_W'($urandom);
      default: ev.micros = USEC_W'($urandom_range(999999));
    endcase
    ev.kind = 1'($urandom_range(1));
    ev.tag = TAG_W'($urandom);
    return ev;
  endfunction

  task automatic offer_item(input logic mode, input toeq_pkg::event_t ev);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_event_seconds <= ev.seconds;
    in_event_micros <= ev.micros;
    in_event_kind <= ev.kind;
    in_event_tag <= ev.tag;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no item actual status %0h fill %0d", $time, out_status,
                 out_fill_count);
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", 32'(want.status), 32'(out_status));
        compare_field("seconds", want.seconds, out_seconds);
        compare_field("micros", 32'(want.micros), 32'(out_micros));
        compare_field("kind", 32'(want.kind), 32'(out_kind));
        compare_field("tag", 32'(want.tag), 32'(out_tag));
        compare_field("next_valid", 32'(want.next_valid), 32'(out_next_valid));
        compare_field("delta_seconds", want.delta_seconds, out_delta_seconds);
        compare_field("delta_micros", 32'(want.delta_micros), 32'(out_delta_micros));
        compare_field("fill_count", 32'(want.fill), 32'(out_fill_count));
      end
    end
  end

  initial begin
    timer_result_t got_pred;
    timer_result_t typed_res;
    toeq_pkg::event_t ev;
    logic mode;
    logic [SEC_W-1:0] epoch;
    int push_pct;

    plan_row(toeq_pkg::MODE_PULL, make_event('0, '0, 1'b0, '0), 1'b1,
             toeq_pkg::ST_QUEUE_EMPT, FILL_W'(0));
    plan_row(toeq_pkg::MODE_PUSH, make_event('1, '1, 1'b1, '1), 1'b1,
             toeq_pkg::ST_PUSH_DONE, FILL_W'(1));
    plan_row(toeq_pkg::MODE_PUSH, make_event('0, '0, 1'b0, '0), 1'b1,
             toeq_pkg::ST_PUSH_DONE, FILL_W'(2));
    plan_row(toeq_pkg::MODE_PUSH, make_event(SEC_W'(5), USEC_W'(999999), 1'b1, 16'h1234),
             1'b1, toeq_pkg::ST_PUSH_DONE, FILL_W'(3));
    plan_row(toeq_pkg::MODE_PUSH, make_event(SEC_W'(6), '0, 1'b0, 16'h5678), 1'b1,
             toeq_pkg::ST_PUSH_DONE, FILL_W'(4));
    // equal deadline: lands ahead of the stored one
    plan_row(toeq_pkg::MODE_PUSH, make_event(SEC_W'(5), USEC_W'(999999), 1'b0, 16'haaaa),
             1'b1, toeq_pkg::ST_PUSH_DONE, FILL_W'(5));
    // micros above one second, then a borrow that wraps
    plan_row(toeq_pkg::MODE_PUSH, make_event(SEC_W'(7), '1, 1'b1, 16'h0101), 1'b1,
             toeq_pkg::ST_PUSH_DONE, FILL_W'(6));
    plan_row(toeq_pkg::MODE_PUSH, make_event(SEC_W'(8), '0, 1'b0, 16'h0202), 1'b1,
             toeq_pkg::ST_PUSH_DONE, FILL_W'(7));
    for (int k = 0; k < 9; k++)
      plan_row(toeq_pkg::MODE_PUSH,
               make_event(SEC_W'(100 + k), USEC_W'(k * 111111), k[0], TAG_W'(16'h1000 + k)),
               1'b1, toeq_pkg::ST_PUSH_DONE, FILL_W'(8 + k));
    plan_row(toeq_pkg::MODE_PUSH, make_event(SEC_W'(3), USEC_W'(3), 1'b1, 16'h0303), 1'b1,
             toeq_pkg::ST_QUEUE_FULL, FILL_W'(16));
    for (int k = 0; k < 6; k++)
      plan_row(toeq_pkg::MODE_PULL, make_event('1, '1, 1'b1, '1), 1'b0,
               toeq_pkg::ST_PULL_DONE, FILL_W'(0));

    send_idle_pct = 26;
    recv_idle_pct = 69;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      offer_item(directed_plan[i].mode, directed_plan[i].ev);
      got_pred = timer_queue_step(directed_plan[i].mode, directed_plan[i].ev);
      if (directed_plan[i].typed) begin
        typed_res = '0;
        typed_res.status = directed_plan[i].status;
        typed_res.fill = directed_plan[i].fill;
        awaited_results.push_back(typed_res);
      end else begin
        awaited_results.push_back(got_pred);
      end
    end

    epoch = '0;
    push_pct = 50;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 26 : 0;
      // hold the receiver off while items keep coming
      if (phase == 2)
        hold_requests <= hold_requests + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % BURST_ITEMS == 0) begin
          case ($urandom_range(3))
            0: push_pct = 15;
            1: push_pct = 50;
            2: push_pct = 85;
            default: push_pct = 97;
          endcase
          case ($urandom_range(5))
            0: epoch = '0;
            1: epoch = 32'hffff_fffc;
            default: epoch = $urandom;
          endcase
        end
        mode = ($urandom_range(99) < push_pct) ? toeq_pkg::MODE_PUSH : toeq_pkg::MODE_PULL;
        ev = random_event(epoch);
        offer_item(mode, ev);
        awaited_results.push_back(timer_queue_step(mode, ev));
      end
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("time_ordered_event_queue_unit verification clean");
    end else begin
      $display("time_ordered_event_queue_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== time_ordered_event_queue_unit.f =====
rtl/toeq_pkg.sv
rtl/toeq_cell.sv
rtl/toeq_delta.sv
rtl/time_ordered_event_queue_unit.sv
tb/sv/testbench.sv
